/* sv/gre_pkg.sv */
`default_nettype none
package gre_pkg;

  localparam int BYTE_W     = 8;
  localparam int DEG_W      = 30;   // whole degrees of a field of up to 15 digits
  localparam int REM_W      = 20;   // remainder below one million
  localparam int SUM_W      = 24;   // remainder times ten plus a digit
  localparam int FRAC_W     = 21;
  localparam int OUT_DEG_W  = 31;
  localparam int MILLION    = 1000000;
  localparam int TAG_LEN    = 8;
  localparam int TAG_POS_W  = 3;

  // floor(x / 3) = (x * RECIP3) >> RECIP3_SHIFT for x below 2**23
  localparam int RECIP_W      = 24;
  localparam int FIVE_REM_W   = 23;
  localparam logic [RECIP_W-1:0] RECIP3 = 24'hAAAAAB;
  localparam int RECIP3_SHIFT = 25;

  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
  localparam logic [BYTE_W-1:0] CH_W     = 8'h57;

  // "+QGPSLOC"
  localparam logic [BYTE_W-1:0] TAG_TEXT [TAG_LEN] = '{
    8'h2B, 8'h51, 8'h47, 8'h50, 8'h53, 8'h4C, 8'h4F, 8'h43
  };

  typedef enum logic [8:0] {
    PH_FIRST = 9'b000000001,
    PH_COLON = 9'b000000010,
    PH_WS    = 9'b000000100,
    PH_SKIP  = 9'b000001000,
    PH_LAT   = 9'b000010000,
    PH_COMMA = 9'b000100000,
    PH_LON   = 9'b001000000,
    PH_DONE  = 9'b010000000,
    PH_FAIL  = 9'b100000000
  } scan_phase_t;

  typedef struct packed {
    logic             neg;
    logic [DEG_W-1:0] deg;
    logic [REM_W-1:0] rem;
  } coord_hold_t;

  typedef struct packed {
    logic        fix;
    coord_hold_t lat;
    coord_hold_t lon;
  } fix_job_t;

  function automatic logic [SUM_W-1:0] millions(input logic [3:0] k);
    return SUM_W'(32'(k) * MILLION);
  endfunction

  function automatic logic is_ws(input logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_field_char(input logic [BYTE_W-1:0] c);
    return (c == CH_DOT) || (c >= CH_ZERO && c <= CH_NINE);
  endfunction

endpackage
`default_nettype wire

/* sv/gre_channels.sv */
`default_nettype none
interface gre_rsp_if;
  import gre_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              end_of_response;

  modport source (output valid, rx_byte, end_of_response, input ready);
  modport sink (input valid, rx_byte, end_of_response, output ready);
endinterface

interface gre_fix_if;
  import gre_pkg::*;
  logic                        valid;
  logic                        ready;
  logic                        fix_valid;
  logic signed [OUT_DEG_W-1:0] lat_degrees;
  logic        [FRAC_W-1:0]    lat_millionths;
  logic signed [OUT_DEG_W-1:0] lon_degrees;
  logic        [FRAC_W-1:0]    lon_millionths;

  modport source (output valid, fix_valid, lat_degrees, lat_millionths, lon_degrees,
                  lon_millionths, input ready);
  modport sink (input valid, fix_valid, lat_degrees, lat_millionths, lon_degrees,
                lon_millionths, output ready);
endinterface
`default_nettype wire

/* sv/gre_tag_match.sv */
`default_nettype none
module gre_tag_match (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire logic                  clear,
  input  wire logic [gre_pkg::BYTE_W-1:0] rx_byte,
  output logic                       seen_next
);
  import gre_pkg::*;

  logic [TAG_POS_W-1:0] pos;
  logic [TAG_POS_W-1:0] pos_next;
  logic                 seen;

  always_comb begin
    pos_next  = pos;
    seen_next = seen;
    if (step) begin
      if (rx_byte == TAG_TEXT[pos]) begin
        pos_next = pos + 1'b1;
        // wraps to zero after the last tag character
        if (pos == TAG_POS_W'(TAG_LEN - 1)) begin
          seen_next = 1'b1;
        end
      end else begin
        pos_next = (rx_byte == CH_PLUS) ? TAG_POS_W'(1) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      pos  <= '0;
      seen <= 1'b0;
    end else begin
      pos  <= pos_next;
      seen <= seen_next;
    end
  end

endmodule
`default_nettype wire

/* sv/gre_scanner.sv */
`default_nettype none
module gre_scanner #(
  parameter int RESPONSE_BYTES = 300,
  parameter int FIELD_CHARS    = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire logic [gre_pkg::BYTE_W-1:0] rx_byte,
  input  wire logic                  last,
  output logic                       job_valid,
  output gre_pkg::fix_job_t          job
);
  import gre_pkg::*;

  localparam int BT_W = $clog2(RESPONSE_BYTES);
  localparam int FC_W = $clog2(FIELD_CHARS + 1);

  scan_phase_t       phase, phase_next;
  logic [BT_W-1:0]   bytes_taken;
  logic              text_ended;
  logic [FC_W-1:0]   cnt, cnt_next;
  logic [DEG_W-1:0]  acc_deg, acc_deg_next;
  logic [REM_W-1:0]  acc_rem, acc_rem_next;
  coord_hold_t       lat, lat_next, lon, lon_next;

  logic              in_window;
  logic              take;
  logic              tag_seen_next;
  logic [SUM_W-1:0]  sum;
  logic [3:0]        carry;
  logic [DEG_W-1:0]  step_deg;
  logic [REM_W-1:0]  step_rem;
  coord_hold_t       hold_now;

  assign in_window = accept && !text_ended && (bytes_taken < BT_W'(RESPONSE_BYTES - 1));
  assign take      = in_window && (rx_byte != CH_NUL);

  gre_tag_match u_tag (
    .clk       (clk),
    .rst       (rst),
    .step      (take),
    .clear     (accept && last),
    .rx_byte   (rx_byte),
    .seen_next (tag_seen_next)
  );

  // decimal digit shift kept split as degrees and remainder below one million
  always_comb begin
    sum = ({4'b0, acc_rem} << 3) + ({4'b0, acc_rem} << 1) + SUM_W'(rx_byte[3:0]);
    carry = '0;
    for (int j = 1; j <= 9; j++) begin
      if (sum >= millions(4'(j))) begin
        carry = 4'(j);
      end
    end
    step_rem = REM_W'(sum - millions(carry));
    step_deg = (acc_deg << 3) + (acc_deg << 1) + DEG_W'(carry);
  end

  assign hold_now = '{neg: (rx_byte == CH_S) || (rx_byte == CH_W), deg: acc_deg, rem: acc_rem};

  always_comb begin
    phase_next   = phase;
    cnt_next     = cnt;
    acc_deg_next = acc_deg;
    acc_rem_next = acc_rem;
    lat_next     = lat;
    lon_next     = lon;
    if (take) begin
      case (phase)
        PH_FIRST: begin
          phase_next = (rx_byte == CH_COLON) ? PH_FAIL : PH_COLON;
        end
        PH_COLON: begin
          if (rx_byte == CH_COLON) begin
            phase_next = PH_WS;
          end
        end
        PH_WS: begin
          if (rx_byte == CH_COMMA) begin
            phase_next = PH_FAIL;
          end else if (!is_ws(rx_byte)) begin
            phase_next = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (rx_byte == CH_COMMA) begin
            phase_next   = PH_LAT;
            cnt_next     = '0;
            acc_deg_next = '0;
            acc_rem_next = '0;
          end
        end
        PH_COMMA: begin
          if (rx_byte == CH_COMMA) begin
            phase_next   = PH_LON;
            cnt_next     = '0;
            acc_deg_next = '0;
            acc_rem_next = '0;
          end else begin
            phase_next = PH_FAIL;
          end
        end
        PH_LAT, PH_LON: begin
          if (cnt < FC_W'(FIELD_CHARS) && is_field_char(rx_byte)) begin
            if (rx_byte != CH_DOT) begin
              acc_deg_next = step_deg;
              acc_rem_next = step_rem;
            end
            cnt_next = cnt + 1'b1;
          end else if (cnt == '0) begin
            phase_next = PH_FAIL;
          end else if (phase == PH_LAT) begin
            lat_next   = hold_now;
            phase_next = PH_COMMA;
          end else begin
            lon_next   = hold_now;
            phase_next = PH_DONE;
          end
        end
        PH_DONE, PH_FAIL: begin
        end
        default: begin
          phase_next = PH_FAIL;
        end
      endcase
    end
  end

  assign job_valid = accept && last;
  assign job       = '{fix: tag_seen_next && (phase_next == PH_DONE), lat: lat_next,
                       lon: lon_next};

  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      phase       <= PH_FIRST;
      bytes_taken <= '0;
      text_ended  <= 1'b0;
      cnt         <= '0;
      acc_deg     <= '0;
      acc_rem     <= '0;
      lat         <= '0;
      lon         <= '0;
    end else begin
      phase   <= phase_next;
      cnt     <= cnt_next;
      acc_deg <= acc_deg_next;
      acc_rem <= acc_rem_next;
      lat     <= lat_next;
      lon     <= lon_next;
      if (take) begin
        bytes_taken <= bytes_taken + 1'b1;
      end
      if (in_window && rx_byte == CH_NUL) begin
        text_ended <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/gre_convert.sv */
`default_nettype none
module gre_convert (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          job_valid,
  input  wire gre_pkg::fix_job_t job,
  output logic               job_ready,
  gre_fix_if.source          fix_out
);
  import gre_pkg::*;

  logic     s1_valid;
  fix_job_t s1;
  logic     out_valid;
  logic     out_adv;
  logic     s1_move;

  // minutes remainder to millionths of a degree: floor(rem * 5 / 3)
  function automatic logic [FRAC_W-1:0] to_frac(input logic [REM_W-1:0] rem);
    logic [FIVE_REM_W-1:0]         five;
    logic [FIVE_REM_W+RECIP_W-1:0] prod;
    five = (FIVE_REM_W'(rem) << 2) + FIVE_REM_W'(rem);
    prod = (FIVE_REM_W+RECIP_W)'(five) * (FIVE_REM_W+RECIP_W)'(RECIP3);
    return prod[RECIP3_SHIFT +: FRAC_W];
  endfunction

  function automatic logic [OUT_DEG_W-1:0] signed_deg(input coord_hold_t h);
    logic [OUT_DEG_W-1:0] d;
    d = OUT_DEG_W'(h.deg);
    return h.neg ? (~d + 1'b1) : d;
  endfunction

  assign out_adv   = !out_valid || fix_out.ready;
  assign s1_move   = s1_valid && out_adv;
  assign job_ready = !s1_valid || out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (job_ready) begin
        s1_valid <= job_valid;
      end
      if (out_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      s1 <= job;
    end
    if (s1_move) begin
      fix_out.fix_valid <= s1.fix;
      if (s1.fix) begin
        fix_out.lat_degrees    <= signed_deg(s1.lat);
        fix_out.lat_millionths <= to_frac(s1.lat.rem);
        fix_out.lon_degrees    <= signed_deg(s1.lon);
        fix_out.lon_millionths <= to_frac(s1.lon.rem);
      end else begin
        fix_out.lat_degrees    <= '0;
        fix_out.lat_millionths <= '0;
        fix_out.lon_degrees    <= '0;
        fix_out.lon_millionths <= '0;
      end
    end
  end

  assign fix_out.valid = out_valid;

endmodule
`default_nettype wire

/* sv/gps_response_coord_extractor_core.sv */
`default_nettype none
// Scans a modem position response one byte per cycle while not stalled and returns one
// fix item per response, on the byte flagged end_of_response. fix_valid is 1 only when
// the "+QGPSLOC" tag appeared and both coordinate fields matched, each closed by any
// one character read as its direction letter; otherwise all coordinate fields read 0.
// Coordinates come as signed whole degrees (negative for S or W, zero degrees never
// negative) plus millionths of a degree taken from the ddmm minutes. Only the first
// RESPONSE_BYTES-1 bytes up to any zero byte are scanned. A byte is accepted every
// cycle that the input is not stalled; the fix item is registered in the stage that
// captures the scan result, then in the output stage that does the minutes-to-millionths
// multiply. Input stalls only while both of those stages hold items that the output side has not taken.
module gps_response_coord_extractor_core #(
  parameter int RESPONSE_BYTES = 300,
  parameter int FIELD_CHARS    = 15
) (
  input  wire logic  clk,
  input  wire logic  rst,
  gre_rsp_if.sink    rsp_in,
  gre_fix_if.source  fix_out
);
  import gre_pkg::*;

  logic     accept;
  logic     job_valid;
  logic     job_ready;
  fix_job_t job;

  assign accept       = rsp_in.valid && rsp_in.ready;
  assign rsp_in.ready = job_ready;

  gre_scanner #(
    .RESPONSE_BYTES (RESPONSE_BYTES),
    .FIELD_CHARS    (FIELD_CHARS)
  ) u_scanner (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rsp_in.rx_byte),
    .last      (rsp_in.end_of_response),
    .job_valid (job_valid),
    .job       (job)
  );

  gre_convert u_convert (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready),
    .fix_out   (fix_out)
  );

endmodule
`default_nettype wire
